// ----- sv/mns_pkg.sv -----
// mns_pkg: types, character codes and tables for the mml note sequencer
// no dependencies
`default_nettype none
package mns_pkg;

    typedef enum logic [3:0] {
        PH_IDLE, PH_NOTE_LETTER, PH_NOTE_ACC, PH_NOTE_NUM, PH_NOTE_DOT,
        PH_NUM_O, PH_NUM_Q, PH_NUM_T, PH_NUM_L, PH_L_DOT,
        PH_DOLLAR, PH_KAR_SEEK, PH_KAR_TEXT, PH_KAR_ESC, PH_SKIP
    } t_phase;

    typedef enum logic [4:0] {
        SQ_WAIT, SQ_PARSE, SQ_ERR1, SQ_RES, SQ_RESW, SQ_DOT, SQ_LDIV, SQ_LDIVW,
        SQ_FDIV, SQ_FDIVW, SQ_FMUL, SQ_TONE, SQ_GATE, SQ_SIL, SQ_REST, SQ_FULL,
        SQ_DISP
    } t_seq;

    typedef struct packed {
        logic err1;
        logic res;
        logic dot;
        logic flush;
        logic tied;
        logic ldiv;
        logic ldot;
        logic disp;
        logic err2;
    } t_flags;

    localparam logic [1:0] EV_TONE  = 2'd0;
    localparam logic [1:0] EV_WAIT  = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [7:0] WHOLE_NOTE = 8'd192;
    localparam logic [6:0] TICK_MUL   = 7'd125;
    localparam logic [4:0] TOP_OCT    = 5'd17;
    localparam logic [5:0] LYRIC_MAX  = 6'd30;

    function automatic logic [30:0] tone_tab(input logic [3:0] s);
        logic [30:0] v;
        case (s)
            4'd0:    v = 31'd1071618315;
            4'd1:    v = 31'd1135340056;
            4'd2:    v = 31'd1202850889;
            4'd3:    v = 31'd1274376125;
            4'd4:    v = 31'd1350154473;
            4'd5:    v = 31'd1430438836;
            4'd6:    v = 31'd1515497155;
            4'd7:    v = 31'd1605613306;
            4'd8:    v = 31'd1701088041;
            4'd9:    v = 31'd1802240000;
            4'd10:   v = 31'd1909406767;
            4'd11:   v = 31'd2022946002;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] step_tab(input logic [2:0] i);
        logic [3:0] v;
        case (i)
            3'd0:    v = 4'd9;
            3'd1:    v = 4'd11;
            3'd2:    v = 4'd0;
            3'd3:    v = 4'd2;
            3'd4:    v = 4'd4;
            3'd5:    v = 4'd5;
            3'd6:    v = 4'd7;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic is_note(input logic [7:0] b);
        return (b >= CH_A && b <= CH_G) || b == CH_R;
    endfunction

    function automatic logic is_start(input logic [7:0] b);
        return is_note(b) || b == CH_LT || b == CH_GT || b == CH_O || b == CH_Q ||
               b == CH_L || b == CH_T || b == CH_DOLL || b == CH_NUL;
    endfunction

endpackage
`default_nettype wire

// ----- sv/mns_in_if.sv -----
// mns_in_if: text byte channel, valid/ready with payload
// no dependencies
`default_nettype none
interface mns_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

// ----- sv/mns_out_if.sv -----
// mns_out_if: event channel, valid/ready with payload
// no dependencies
`default_nettype none
interface mns_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [30:0] tone_value;
    logic [15:0] wait_ticks;
    logic        last_event;
    modport source (output valid, output event_kind, output tone_value,
                    output wait_ticks, output last_event, input ready);
    modport sink (input valid, input event_kind, input tone_value,
                  input wait_ticks, input last_event, output ready);
endinterface
`default_nettype wire

// ----- sv/mns_div.sv -----
// mns_div: restoring serial divider, one quotient bit per cycle
// depends on nothing outside this file
`default_nettype none
module mns_div #(
    parameter int W_N = 23,
    parameter int W_D = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [W_N-1:0] i_num,
    input  wire logic [W_D-1:0] i_den,
    output logic                o_busy,
    output logic [W_N-1:0]      o_quo
);
    localparam int CW = $clog2(W_N + 1);

    logic [CW-1:0]  r_cnt;
    logic [W_N-1:0] r_q;
    logic [W_D-1:0] r_r;
    logic [W_D-1:0] r_d;
    logic [W_D:0]   trial;
    logic [W_D:0]   diff;

    assign trial = {r_r, r_q[W_N-1]};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(W_N);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_cnt != '0) begin
            if (trial >= {1'b0, r_d}) begin
                r_r <= diff[W_D-1:0];
                r_q <= {r_q[W_N-2:0], 1'b1};
            end else begin
                r_r <= trial[W_D-1:0];
                r_q <= {r_q[W_N-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
endmodule
`default_nettype wire

// ----- sv/mml_note_sequencer_core.sv -----
// mml_note_sequencer_core: byte-wise mml parser emitting tone, wait and error beats
// depends on mns_pkg, mns_in_if, mns_out_if, mns_div
// One text byte is taken, then ready stays low while a small sequencer works it
// through. A byte that resolves a note length or an L value also waits on the one
// shared serial divider. A byte that plays a note also runs the tick division in
// that divider, the gate product and the tone step, and emits each wait or silence
// beat. Event beats leave through a single output register; the sequencer stalls
// on it when the sink holds ready low.
`default_nettype none
module mml_note_sequencer_core #(
    parameter int DURATION_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mns_in_if.sink     i_in,
    mns_out_if.source  o_out
);
    import mns_pkg::*;

    localparam int DB = DURATION_BITS;
    localparam int WN = DB + 7;

    t_seq         r_state, n_state;
    t_phase       r_phase, n_phase;
    t_flags       r_flags, n_flags;
    logic [7:0]   r_byte, n_byte;
    logic [3:0]   r_oct, n_oct;
    logic [DB-1:0] r_dl, n_dl;
    logic [15:0]  r_tempo, n_tempo;
    logic [7:0]   r_quant, n_quant;
    logic [3:0]   r_prev_oct, n_prev_oct;
    logic [3:0]   r_prev_step, n_prev_step;
    logic [3:0]   r_p_oct, n_p_oct;
    logic [3:0]   r_p_step, n_p_step;
    logic         r_p_rest, n_p_rest;
    logic [15:0]  r_acc, n_acc;
    logic [DB-1:0] r_pl, n_pl;
    logic [5:0]   r_lyric, n_lyric;
    logic [WN-1:0] r_full, n_full;
    logic [WN-1:0] r_gate, n_gate;
    logic         r_ov, n_ov;
    logic [1:0]   r_kind, n_kind;
    logic [30:0]  r_tone, n_tone;
    logic [15:0]  r_wait, n_wait;
    logic         r_last, n_last;

    logic          div_start;
    logic [WN-1:0] div_num;
    logic [15:0]   div_den;
    logic          div_busy;
    logic [WN-1:0] div_quo;

    logic          free;
    logic          digit;
    logic [19:0]   acc_mul;
    logic [15:0]   acc_base;
    logic [15:0]   acc_new;
    logic [WN+7:0] gate_prod;
    logic          split;
    logic [3:0]    cur_oct;
    logic [3:0]    cur_step;
    logic [4:0]    tone_sh;

    mns_div #(.W_N(WN), .W_D(16)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    function automatic logic [DB-1:0] add_dot(input logic [DB-1:0] v);
        logic [DB:0] s;
        s = {1'b0, v} + {2'b0, v[DB-1:1]};
        return s[DB] ? {DB{1'b1}} : s[DB-1:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [WN-1:0] v);
        return (v > WN'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    endfunction

    assign free      = !r_ov || o_out.ready;
    assign digit     = (r_byte >= CH_0) && (r_byte <= CH_9);
    assign acc_base  = (r_phase == PH_NOTE_NUM || r_phase == PH_NUM_O || r_phase == PH_NUM_Q ||
                        r_phase == PH_NUM_T || r_phase == PH_NUM_L) ? r_acc : 16'd0;
    assign acc_mul   = {4'b0, acc_base} * 20'd10 + {16'b0, r_byte[3:0]};
    assign acc_new   = (acc_mul > 20'hFFFF) ? 16'hFFFF : acc_mul[15:0];
    assign gate_prod = {8'b0, r_full} * {{WN{1'b0}}, r_quant};
    assign split     = !r_p_rest && (r_quant < 8'd8) && !r_flags.tied;
    assign cur_oct   = r_p_rest ? 4'd0 : r_p_oct;
    assign cur_step  = r_p_rest ? 4'd0 : r_p_step;
    assign tone_sh   = TOP_OCT - {1'b0, cur_oct};

    assign i_in.ready       = (r_state == SQ_WAIT);
    assign o_out.valid      = r_ov;
    assign o_out.event_kind = r_kind;
    assign o_out.tone_value = r_tone;
    assign o_out.wait_ticks = r_wait;
    assign o_out.last_event = r_last;

    always_comb begin
        n_state = r_state;   n_phase = r_phase;     n_flags = r_flags;
        n_byte = r_byte;     n_oct = r_oct;         n_dl = r_dl;
        n_tempo = r_tempo;   n_quant = r_quant;     n_prev_oct = r_prev_oct;
        n_prev_step = r_prev_step;                  n_p_oct = r_p_oct;
        n_p_step = r_p_step; n_p_rest = r_p_rest;   n_acc = r_acc;
        n_pl = r_pl;         n_lyric = r_lyric;     n_full = r_full;
        n_gate = r_gate;
        n_ov = r_ov && !o_out.ready;
        n_kind = r_kind;     n_tone = r_tone;       n_wait = r_wait;
        n_last = r_last;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = r_acc;

        case (r_state)
            SQ_WAIT: begin
                if (i_in.valid) begin
                    n_byte  = i_in.text_byte;
                    n_state = SQ_PARSE;
                end
            end
            SQ_PARSE: begin
                n_flags = '0;
                n_state = SQ_ERR1;
                case (r_phase)
                    PH_NOTE_LETTER, PH_NOTE_ACC, PH_NOTE_NUM, PH_NOTE_DOT: begin
                        if (r_phase == PH_NOTE_LETTER &&
                            (r_byte == CH_PLUS || r_byte == CH_HASH || r_byte == CH_MINUS)) begin
                            if (!r_p_rest) begin
                                if (r_byte == CH_MINUS) begin
                                    if (r_p_step == 4'd0) begin
                                        n_p_step = 4'd11;
                                        n_p_oct  = r_p_oct - 1'b1;
                                    end else begin
                                        n_p_step = r_p_step - 1'b1;
                                    end
                                end else begin
                                    if (r_p_step == 4'd11) begin
                                        n_p_step = 4'd0;
                                        n_p_oct  = r_p_oct + 1'b1;
                                    end else begin
                                        n_p_step = r_p_step + 1'b1;
                                    end
                                end
                            end
                            n_phase = PH_NOTE_ACC;
                        end else if (digit && r_phase != PH_NOTE_DOT) begin
                            n_acc   = acc_new;
                            n_phase = PH_NOTE_NUM;
                        end else if (r_byte == CH_DOT || r_byte == CH_AMP) begin
                            if (r_phase == PH_NOTE_NUM && r_acc == 16'd0) begin
                                n_flags.err1 = 1'b1;
                                n_phase      = PH_IDLE;
                            end else begin
                                n_flags.res = (r_phase == PH_NOTE_NUM);
                                if (r_byte == CH_DOT) begin
                                    n_flags.dot = 1'b1;
                                    n_phase     = PH_NOTE_DOT;
                                end else begin
                                    n_flags.flush = 1'b1;
                                    n_flags.tied  = 1'b1;
                                    n_phase       = PH_IDLE;
                                end
                            end
                        end else begin
                            if (r_phase == PH_NOTE_NUM && r_acc == 16'd0) begin
                                n_flags.err1 = 1'b1;
                            end else if (is_start(r_byte)) begin
                                n_flags.res   = (r_phase == PH_NOTE_NUM);
                                n_flags.flush = 1'b1;
                            end
                            n_flags.disp = 1'b1;
                            n_flags.err2 = !is_start(r_byte);
                        end
                    end
                    PH_NUM_O, PH_NUM_Q, PH_NUM_T, PH_NUM_L: begin
                        if (digit) begin
                            n_acc = acc_new;
                        end else begin
                            n_flags.disp = 1'b1;
                            n_flags.err2 = !is_start(r_byte);
                            case (r_phase)
                                PH_NUM_O: n_oct = (r_acc > 16'd9) ? 4'd9 : r_acc[3:0];
                                PH_NUM_Q: n_quant = (r_acc > 16'd255) ? 8'd255 : r_acc[7:0];
                                PH_NUM_T: begin
                                    if (r_acc == 16'd0) begin
                                        n_flags.err1 = 1'b1;
                                    end else begin
                                        n_tempo = r_acc;
                                    end
                                end
                                default: begin
                                    if (r_acc == 16'd0) begin
                                        n_flags.err1 = 1'b1;
                                    end else begin
                                        n_flags.ldiv = 1'b1;
                                        if (r_byte == CH_DOT) begin
                                            n_flags.ldot = 1'b1;
                                            n_flags.disp = 1'b0;
                                            n_flags.err2 = 1'b0;
                                            n_phase      = PH_L_DOT;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                    PH_L_DOT: begin
                        if (r_byte == CH_DOT) begin
                            n_dl = add_dot(r_dl);
                        end else begin
                            n_flags.disp = 1'b1;
                            n_flags.err2 = !is_start(r_byte);
                        end
                    end
                    PH_DOLLAR, PH_SKIP: begin
                        if (r_phase == PH_DOLLAR && r_byte == CH_K) begin
                            n_phase = PH_KAR_SEEK;
                        end else if (r_byte == CH_SEMI) begin
                            n_phase = PH_IDLE;
                        end else if (r_byte == CH_NUL) begin
                            n_flags.err1 = 1'b1;
                            n_phase      = PH_IDLE;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_KAR_SEEK: begin
                        if (r_byte == CH_QUOTE) begin
                            n_lyric = '0;
                            n_phase = PH_KAR_TEXT;
                        end else if (r_byte == CH_NUL) begin
                            n_flags.err1 = 1'b1;
                            n_phase      = PH_IDLE;
                        end
                    end
                    PH_KAR_TEXT: begin
                        if (r_byte == CH_QUOTE) begin
                            n_phase = PH_SKIP;
                        end else if (r_byte == CH_NUL || r_lyric >= LYRIC_MAX) begin
                            n_flags.err1 = 1'b1;
                            n_phase      = PH_IDLE;
                        end else if (r_byte == CH_PCT) begin
                            n_phase = PH_KAR_ESC;
                        end else begin
                            n_lyric = r_lyric + 1'b1;
                        end
                    end
                    PH_KAR_ESC: begin
                        if (r_byte == CH_NUL) begin
                            n_flags.err1 = 1'b1;
                            n_phase      = PH_IDLE;
                        end else begin
                            n_lyric = r_lyric + 1'b1;
                            n_phase = PH_KAR_TEXT;
                        end
                    end
                    default: begin
                        n_flags.disp = 1'b1;
                        n_flags.err2 = !is_start(r_byte);
                    end
                endcase
            end
            SQ_ERR1: begin
                if (!r_flags.err1) begin
                    n_state = SQ_RES;
                end else if (free) begin
                    n_ov = 1'b1; n_kind = EV_ERROR; n_tone = '0; n_wait = '0;
                    n_last  = !r_flags.err2;
                    n_state = SQ_RES;
                end
            end
            SQ_RES: begin
                div_num = WN'(WHOLE_NOTE);
                if (r_flags.res) begin
                    div_start = 1'b1;
                    n_state   = SQ_RESW;
                end else begin
                    n_state = SQ_DOT;
                end
            end
            SQ_RESW: begin
                if (!div_busy) begin
                    n_pl    = div_quo[DB-1:0];
                    n_state = SQ_DOT;
                end
            end
            SQ_DOT: begin
                if (r_flags.dot) begin
                    n_pl = add_dot(r_pl);
                end
                n_state = SQ_LDIV;
            end
            SQ_LDIV: begin
                div_num = WN'(WHOLE_NOTE);
                if (r_flags.ldiv) begin
                    div_start = 1'b1;
                    n_state   = SQ_LDIVW;
                end else begin
                    n_state = SQ_FDIV;
                end
            end
            SQ_LDIVW: begin
                if (!div_busy) begin
                    n_dl    = r_flags.ldot ? add_dot(div_quo[DB-1:0]) : div_quo[DB-1:0];
                    n_state = SQ_FDIV;
                end
            end
            SQ_FDIV: begin
                div_num = WN'(r_pl) * WN'(TICK_MUL);
                div_den = r_tempo;
                if (r_flags.flush) begin
                    div_start = 1'b1;
                    n_state   = SQ_FDIVW;
                end else begin
                    n_state = SQ_DISP;
                end
            end
            SQ_FDIVW: begin
                if (!div_busy) begin
                    n_full  = div_quo;
                    n_state = SQ_FMUL;
                end
            end
            SQ_FMUL: begin
                n_gate  = gate_prod[WN+2:3];
                n_state = SQ_TONE;
            end
            SQ_TONE: begin
                if (cur_oct == r_prev_oct && cur_step == r_prev_step) begin
                    n_state = split ? SQ_GATE : SQ_FULL;
                end else if (free) begin
                    n_ov = 1'b1; n_kind = EV_TONE; n_wait = '0; n_last = 1'b0;
                    n_tone      = r_p_rest ? 31'd0 : (tone_tab(cur_step) >> tone_sh);
                    n_prev_oct  = cur_oct;
                    n_prev_step = cur_step;
                    n_state     = split ? SQ_GATE : SQ_FULL;
                end
            end
            SQ_GATE: begin
                if (free) begin
                    n_ov = 1'b1; n_kind = EV_WAIT; n_tone = '0; n_last = 1'b0;
                    n_wait  = sat16(r_gate);
                    n_state = SQ_SIL;
                end
            end
            SQ_SIL: begin
                if (free) begin
                    n_ov = 1'b1; n_kind = EV_TONE; n_tone = '0; n_wait = '0; n_last = 1'b0;
                    n_prev_oct  = 4'd0;
                    n_prev_step = 4'd0;
                    n_state     = SQ_REST;
                end
            end
            SQ_REST, SQ_FULL: begin
                if (free) begin
                    n_ov = 1'b1; n_kind = EV_WAIT; n_tone = '0;
                    n_last  = !r_flags.err2;
                    n_wait  = (r_state == SQ_REST) ? sat16(r_full - r_gate) : sat16(r_full);
                    n_state = SQ_DISP;
                end
            end
            SQ_DISP: begin
                if (!r_flags.disp) begin
                    n_state = SQ_WAIT;
                end else if (!r_flags.err2 || free) begin
                    n_phase = PH_IDLE;
                    n_acc   = '0;
                    n_state = SQ_WAIT;
                    if (r_flags.err2) begin
                        n_ov = 1'b1; n_kind = EV_ERROR; n_tone = '0; n_wait = '0;
                        n_last = 1'b1;
                    end
                    if (is_note(r_byte)) begin
                        n_p_rest = (r_byte == CH_R);
                        if (r_byte == CH_R) begin
                            n_p_oct  = 4'd0;
                            n_p_step = 4'd0;
                        end else begin
                            n_p_oct  = r_oct + 1'b1;
                            n_p_step = step_tab(3'(r_byte - CH_A));
                        end
                        n_pl    = r_dl;
                        n_phase = PH_NOTE_LETTER;
                    end else begin
                        case (r_byte)
                            CH_LT:   if (r_oct > 4'd0) n_oct = r_oct - 1'b1;
                            CH_GT:   if (r_oct < 4'd9) n_oct = r_oct + 1'b1;
                            CH_O:    n_phase = PH_NUM_O;
                            CH_Q:    n_phase = PH_NUM_Q;
                            CH_L:    n_phase = PH_NUM_L;
                            CH_T:    n_phase = PH_NUM_T;
                            CH_DOLL: n_phase = PH_DOLLAR;
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            default: n_state = SQ_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_WAIT;   r_phase <= PH_IDLE;   r_flags <= '0;
            r_oct <= 4'd4;        r_dl <= DB'(48);      r_tempo <= 16'd120;
            r_quant <= 8'd7;      r_prev_oct <= '0;     r_prev_step <= '0;
            r_p_oct <= '0;        r_p_step <= '0;       r_p_rest <= 1'b0;
            r_acc <= '0;          r_pl <= '0;           r_lyric <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;   r_phase <= n_phase;   r_flags <= n_flags;
            r_oct <= n_oct;       r_dl <= n_dl;         r_tempo <= n_tempo;
            r_quant <= n_quant;   r_prev_oct <= n_prev_oct;
            r_prev_step <= n_prev_step;                 r_p_oct <= n_p_oct;
            r_p_step <= n_p_step; r_p_rest <= n_p_rest; r_acc <= n_acc;
            r_pl <= n_pl;         r_lyric <= n_lyric;   r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_full <= n_full;
        r_gate <= n_gate;
        r_kind <= n_kind;
        r_tone <= n_tone;
        r_wait <= n_wait;
        r_last <= n_last;
    end

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken while a byte is in work");
    a_tempo_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tempo != 16'd0)
        else $error("tempo reached zero");
    a_octave_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oct <= 4'd9)
        else $error("octave out of range");
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_emit_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov && n_ov |-> !i_in.ready)
        else $error("event raised while idle");
endmodule
`default_nettype wire

// ----- dv/mns_tb_if.sv -----
// mns_tb_pkg: event record type used by the testbench scoreboard
// depends on mns_pkg; channel interfaces come from sv/mns_in_if.sv and sv/mns_out_if.sv
package mns_tb_pkg;
    import mns_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] tone;
        logic [15:0] ticks;
        logic        last;
    } t_event;
endpackage

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for mml_note_sequencer_core
// drives text bytes, predicts tone, wait and error beats, compares them in order
// depends on mns_pkg, mns_tb_pkg, mns_in_if, mns_out_if and the core rtl
module tb_top;
    import mns_pkg::*;
    import mns_tb_pkg::*;

    localparam int DUR_BITS = 16;
    localparam longint LEN_TOP = (64'd1 << DUR_BITS) - 1;

    class event_scoreboard;
        t_event pending_q[$];
        int errors;
        t_phase ph;
        int oct, dlen, tmp, quant, prev_note, pnote, plen, acc, lcount;
        bit p_rest;
        t_event out_buf[$];

        function void clear();
            pending_q.delete();
            errors = 0; ph = PH_IDLE; oct = 4; dlen = 48; tmp = 120; quant = 7;
            prev_note = 0; pnote = 0; plen = 0; acc = 0; lcount = 0; p_rest = 0;
        endfunction

        function void push(logic [1:0] k, longint tn, longint tk);
            t_event e;
            if (out_buf.size() >= 4) return;
            e.kind = k; e.tone = tn[30:0]; e.ticks = tk[15:0]; e.last = 0;
            out_buf.push_back(e);
        endfunction

        function longint tone_for(int n);
            int o;
            o = n / 12;
            if (o > 17) o = 17;
            return longint'(tone_tab(4'(n % 12))) >> (17 - o);
        endfunction

        function int dotted(int v);
            longint r;
            r = longint'(v) + v / 2;
            return (r > LEN_TOP) ? int'(LEN_TOP) : int'(r);
        endfunction

        function void digit_in(logic [7:0] b);
            int v;
            v = acc * 10 + (b - CH_0);
            acc = (v > 65535) ? 65535 : v;
        endfunction

        function longint sat(longint t);
            return (t > 65535) ? 65535 : t;
        endfunction

        function void play(bit tied);
            int n;
            longint full, gate;
            n = p_rest ? 0 : pnote;
            full = (longint'(plen) * 125) / (tmp != 0 ? tmp : 1);
            if (n != prev_note) begin
                push(EV_TONE, p_rest ? 0 : tone_for(n), 0);
                prev_note = n;
            end
            if (!p_rest && quant < 8 && !tied) begin
                gate = full * quant / 8;
                push(EV_WAIT, 0, sat(gate));
                push(EV_TONE, 0, 0);
                prev_note = 0;
                push(EV_WAIT, 0, sat(full - gate));
            end else begin
                push(EV_WAIT, 0, sat(full));
            end
        endfunction

        function void start_cmd(logic [7:0] b);
            ph = PH_IDLE;
            acc = 0;
            if (is_note(b)) begin
                p_rest = (b == CH_R);
                pnote = p_rest ? 0 : (oct * 12 + step_tab(3'(b - CH_A)) + 12) & 8'hff;
                plen = dlen;
                ph = PH_NOTE_LETTER;
            end else if (b == CH_LT) begin
                if (oct > 0) oct--;
            end else if (b == CH_GT) begin
                if (oct < 9) oct++;
            end else if (b == CH_O) ph = PH_NUM_O;
            else if (b == CH_Q) ph = PH_NUM_Q;
            else if (b == CH_L) ph = PH_NUM_L;
            else if (b == CH_T) ph = PH_NUM_T;
            else if (b == CH_DOLL) ph = PH_DOLLAR;
            else if (b != CH_NUL) push(EV_ERROR, 0, 0);
        endfunction

        function void skip_in(logic [7:0] b);
            if (b == CH_SEMI) ph = PH_IDLE;
            else if (b == CH_NUL) begin
                push(EV_ERROR, 0, 0);
                ph = PH_IDLE;
            end else ph = PH_SKIP;
        endfunction

        function bit take_len();
            if (acc == 0) return 0;
            plen = 192 / acc;
            return 1;
        endfunction

        function void note_in(logic [7:0] b);
            bit dig;
            t_phase p;
            dig = (b >= CH_0 && b <= CH_9);
            p = ph;
            if (p == PH_NOTE_LETTER && (b == CH_PLUS || b == CH_HASH || b == CH_MINUS)) begin
                if (!p_rest) pnote = (b == CH_MINUS ? pnote - 1 : pnote + 1) & 8'hff;
                ph = PH_NOTE_ACC;
                return;
            end
            if (dig && p != PH_NOTE_DOT) begin
                if (p != PH_NOTE_NUM) acc = 0;
                digit_in(b);
                ph = PH_NOTE_NUM;
                return;
            end
            if (b == CH_DOT || b == CH_AMP) begin
                if (p == PH_NOTE_NUM && !take_len()) begin
                    push(EV_ERROR, 0, 0);
                    ph = PH_IDLE;
                    return;
                end
                if (b == CH_DOT) begin
                    plen = dotted(plen);
                    ph = PH_NOTE_DOT;
                end else begin
                    play(1);
                    ph = PH_IDLE;
                end
                return;
            end
            if (p == PH_NOTE_NUM && !take_len()) push(EV_ERROR, 0, 0);
            else if (is_start(b)) play(0);
            start_cmd(b);
        endfunction

        function void note_byte(logic [7:0] b);
            bit dig;
            dig = (b >= CH_0 && b <= CH_9);
            out_buf.delete();
            case (ph)
                PH_NOTE_LETTER, PH_NOTE_ACC, PH_NOTE_NUM, PH_NOTE_DOT: note_in(b);
                PH_NUM_O, PH_NUM_Q, PH_NUM_T, PH_NUM_L: begin
                    if (dig) digit_in(b);
                    else begin
                        bit held;
                        held = 0;
                        if (ph == PH_NUM_O) oct = (acc > 9) ? 9 : acc;
                        else if (ph == PH_NUM_Q) quant = (acc > 255) ? 255 : acc;
                        else if (ph == PH_NUM_T) begin
                            if (acc == 0) push(EV_ERROR, 0, 0);
                            else tmp = acc;
                        end else if (acc == 0) push(EV_ERROR, 0, 0);
                        else begin
                            dlen = 192 / acc;
                            if (b == CH_DOT) begin
                                dlen = dotted(dlen);
                                ph = PH_L_DOT;
                                held = 1;
                            end
                        end
                        if (!held) start_cmd(b);
                    end
                end
                PH_L_DOT: begin
                    if (b == CH_DOT) dlen = dotted(dlen);
                    else start_cmd(b);
                end
                PH_DOLLAR: begin
                    if (b == CH_K) ph = PH_KAR_SEEK;
                    else skip_in(b);
                end
                PH_KAR_SEEK: begin
                    if (b == CH_QUOTE) begin
                        lcount = 0;
                        ph = PH_KAR_TEXT;
                    end else if (b == CH_NUL) begin
                        push(EV_ERROR, 0, 0);
                        ph = PH_IDLE;
                    end
                end
                PH_KAR_TEXT: begin
                    if (b == CH_QUOTE) ph = PH_SKIP;
                    else if (b == CH_NUL || lcount >= 30) begin
                        push(EV_ERROR, 0, 0);
                        ph = PH_IDLE;
                    end else if (b == CH_PCT) ph = PH_KAR_ESC;
                    else lcount++;
                end
                PH_KAR_ESC: begin
                    if (b == CH_NUL) begin
                        push(EV_ERROR, 0, 0);
                        ph = PH_IDLE;
                    end else begin
                        lcount++;
                        ph = PH_KAR_TEXT;
                    end
                end
                PH_SKIP: skip_in(b);
                default: start_cmd(b);
            endcase
            if (out_buf.size() > 0) out_buf[out_buf.size() - 1].last = 1;
            foreach (out_buf[i]) pending_q.push_back(out_buf[i]);
        endfunction

        function void check_event(t_event got);
            t_event w;
            if (pending_q.size() == 0) begin
                $error("unexpected beat kind=%0d tone=%0d ticks=%0d",
                       got.kind, got.tone, got.ticks);
                errors++;
                return;
            end
            w = pending_q.pop_front();
            if (got.kind !== w.kind) begin
                $error("event_kind expected %0d actual %0d", w.kind, got.kind);
                errors++;
            end
            if (got.tone !== w.tone) begin
                $error("tone_value expected %0d actual %0d", w.tone, got.tone);
                errors++;
            end
            if (got.ticks !== w.ticks) begin
                $error("wait_ticks expected %0d actual %0d", w.ticks, got.ticks);
                errors++;
            end
            if (got.last !== w.last) begin
                $error("last_event expected %0d actual %0d", w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    int send_idle = 12;
    int recv_idle = 49;
    event_scoreboard sb;

    mns_in_if  in_ch ();
    mns_out_if out_ch ();

    mml_note_sequencer_core #(.DURATION_BITS(DUR_BITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.text_byte = 0;
        out_ch.ready = 0;
    end

    // receiver: random stall, check on accepted beats
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_event e;
            e.kind = out_ch.event_kind;
            e.tone = out_ch.tone_value;
            e.ticks = out_ch.wait_ticks;
            e.last = out_ch.last_event;
            sb.check_event(e);
        end
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.text_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    task automatic send_number(input int hi);
        send_text($sformatf("%0d", $urandom_range(hi)));
    endtask

    task automatic send_phrase();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_byte(8'(CH_A + $urandom_range(6)));
            if ($urandom_range(3) == 0) send_byte(8'("+#-" >> (8 * $urandom_range(2))));
            if ($urandom_range(1)) send_number($urandom_range(3) == 0 ? 99999 : 64);
            repeat ($urandom_range(2)) send_byte(CH_DOT);
            if ($urandom_range(4) == 0) send_byte(CH_AMP);
        end else if (pick < 60) begin
            send_byte(CH_R);
            if ($urandom_range(1)) send_number(32);
        end else if (pick < 64) send_byte($urandom_range(1) ? CH_LT : CH_GT);
        else if (pick < 68) begin
            send_byte(CH_O);
            send_number(12);
        end else if (pick < 72) begin
            send_byte(CH_Q);
            send_number($urandom_range(1) ? 9 : 300);
        end else if (pick < 76) begin
            send_byte(CH_T);
            send_number($urandom_range(1) ? 255 : 70000);
        end else if (pick < 80) begin
            send_byte(CH_L);
            send_number(64);
            repeat ($urandom_range(2)) send_byte(CH_DOT);
        end else if (pick < 85) begin
            send_text("$K\"");
            repeat ($urandom_range(33)) send_byte(8'($urandom_range(8'h26, 8'h7e)));
            send_text("\";");
        end else if (pick < 88) begin
            send_byte(CH_DOLL);
            repeat ($urandom_range(4)) send_byte(8'($urandom_range(8'h41, 8'h5a)));
            send_byte(CH_SEMI);
        end else if (pick < 92) send_byte(CH_NUL);
        else send_byte(8'($urandom_range(255)));
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: notes, accidentals, dots, ties, commands, errors, lyrics
        send_text("CD+E-8.F#&G0A16..BR+4");
        send_text("O9C>C<O0C<CO12BQ8CQ300CT0L0LT65535C1.L1..C");
        send_text("T1Q0C1Z$K\"AB%\"C\";");
        send_byte(8'hff);
        send_text("$K\"ABCDEFGHIJKLMNOPQRSTUVWXYZ12345\"");
        send_text("$AB%");
        send_byte(CH_NUL);
        send_text("$K\"%");
        send_byte(CH_NUL);
        send_text("T120Q7L4O4C99999");
        send_byte(CH_NUL);
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle = 49;
                recv_idle = 12;
            end else if (phase == 2) begin
                send_idle = 0;
                recv_idle = 0;
            end
            repeat (6) send_phrase();
        end
        drain();
        if (sb.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
